@@ hw/rtl/nass_pkg.sv @@
package nass_pkg;

  // Request kinds on the input tuser
  localparam logic [1:0] REQ_START = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_WORD  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_BUSY      = 3'd0;
  localparam logic [2:0] ST_INIT_DONE = 3'd1;
  localparam logic [2:0] ST_ID_BAD    = 3'd2;
  localparam logic [2:0] ST_ECHO_BAD  = 3'd3;
  localparam logic [2:0] ST_REFUSED   = 3'd4;
  localparam logic [2:0] ST_FRAME_END = 3'd5;

  localparam int unsigned CHANNELS_DEF = 16;
  localparam int unsigned STEP_W       = 7;
  localparam int unsigned GRP_W        = 5;

  // Command words
  localparam logic [15:0] CMD_DUMMY = 16'hC000;
  localparam logic [15:0] CMD_CLEAR = 16'h6A00;
  localparam logic [15:0] CMD_CAL   = 16'h5500;
  localparam logic [15:0] CMD_PAD   = 16'hFF00;
  localparam logic [5:0]  ROM_BASE  = 6'd40;

  // Start-up sequence landmarks (step numbers)
  localparam logic [STEP_W-1:0] S_CLEAR    = 7'd12;
  localparam logic [STEP_W-1:0] S_ROM      = 7'd15;
  localparam logic [STEP_W-1:0] S_ROM_LAST = 7'd29;
  localparam logic [STEP_W-1:0] S_REG      = 7'd30;
  localparam logic [STEP_W-1:0] S_REG_END  = 7'd84;
  localparam logic [STEP_W-1:0] S_PAD_END  = 7'd94;
  localparam logic [STEP_W-1:0] S_LAST     = 7'd95;

  // One result item
  typedef struct packed {
    logic        tx_valid;
    logic [15:0] tx_word;
    logic        sample_valid;
    logic [3:0]  channel;
    logic [15:0] sample_value;
    logic [31:0] timestamp;
    logic [2:0]  status;
    logic [4:0]  failed_index;
    logic        frame_last;
  } res_t;

  // Register write commands of the start-up sequence
  function automatic logic [15:0] reg_word(input logic [GRP_W-1:0] k);
    logic [15:0] w;
    case (k)
      5'd0:    w = 16'h80DE;
      5'd1:    w = 16'h8120;
      5'd2:    w = 16'h8228;
      5'd3:    w = 16'h8302;
      5'd4:    w = 16'h84B0;
      5'd5:    w = 16'h8500;
      5'd6:    w = 16'h8600;
      5'd7:    w = 16'h8700;
      5'd8:    w = 16'h882C;
      5'd9:    w = 16'h8911;
      5'd10:   w = 16'h8A08;
      5'd11:   w = 16'h8B15;
      5'd12:   w = 16'h8C10;
      5'd13:   w = 16'h8D3C;
      5'd14:   w = 16'h8EFF;
      5'd15:   w = 16'h8FFF;
      5'd16:   w = 16'h90FF;
      5'd17:   w = 16'h91FF;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

  // Expected ID characters from the ROM reads
  function automatic logic [7:0] id_char(input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = 8'h49;
      3'd1:    c = 8'h4E;
      3'd2:    c = 8'h54;
      3'd3:    c = 8'h41;
      3'd4:    c = 8'h4E;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Start-up command for step s; slot is the position within a 3-step group and k the group number
  function automatic logic [15:0] init_cmd(input logic [STEP_W-1:0] s,
                                           input logic [1:0]        slot,
                                           input logic [GRP_W-1:0]  k);
    logic [15:0] w;
    logic [5:0]  addr;
    addr = ROM_BASE + 6'(k[2:0]);
    if (s < S_ROM) begin
      w = (s == S_CLEAR) ? CMD_CLEAR : CMD_DUMMY;
    end else if (s < S_REG) begin
      w = (slot == 2'd0) ? (CMD_DUMMY | {2'b00, addr, 8'h00}) : CMD_DUMMY;
    end else if (s < S_REG_END) begin
      w = (slot == 2'd0) ? reg_word(k) : CMD_DUMMY;
    end else if (s == S_REG_END) begin
      w = CMD_CAL;
    end else if (s < S_PAD_END) begin
      w = CMD_PAD;
    end else begin
      w = CMD_DUMMY;
    end
    return w;
  endfunction

endpackage

@@ hw/rtl/nass_core.sv @@
module nass_core #(
  parameter int unsigned CHANNELS = nass_pkg::CHANNELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_en_i,
  input  logic [1:0]         req_i,
  input  logic [15:0]        rx_i,
  input  logic [31:0]        now_i,
  output nass_pkg::res_t     res_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_INIT,
    PH_FRAME
  } phase_e;

  localparam logic [nass_pkg::STEP_W-1:0] FRAME_END = nass_pkg::STEP_W'(CHANNELS + 2);
  localparam logic [nass_pkg::STEP_W-1:0] CH_LAST   = nass_pkg::STEP_W'(CHANNELS + 1);
  localparam logic [nass_pkg::STEP_W-1:0] CH_NUM    = nass_pkg::STEP_W'(CHANNELS);

  phase_e                          phase_q, phase_d;
  logic [nass_pkg::STEP_W-1:0]     step_q, step_d;
  logic [1:0]                      slot_q, slot_d;
  logic [nass_pkg::GRP_W-1:0]      grp_q, grp_d;
  logic                            init_q, init_d;
  logic                            id_bad_q, id_bad_d;
  logic [2:0]                      id_idx_q, id_idx_d;
  logic [31:0]                     start_q, start_d;
  logic [31:0]                     stamp_q, stamp_d;

  logic [nass_pkg::STEP_W-1:0]     nxt_step;
  logic [1:0]                      nxt_slot;
  logic [nass_pkg::GRP_W-1:0]      nxt_grp;
  logic                            in_rom, in_reg, echo_bad;
  logic [7:0]                      echo_exp;
  nass_pkg::res_t                  res;

  // Position of the following step inside its 3-step group
  always_comb begin
    nxt_step = step_q + 1'b1;
    if (nxt_step == nass_pkg::S_ROM || nxt_step == nass_pkg::S_REG) begin
      nxt_slot = 2'd0;
      nxt_grp  = '0;
    end else if (slot_q == 2'd2) begin
      nxt_slot = 2'd0;
      nxt_grp  = grp_q + 1'b1;
    end else begin
      nxt_slot = slot_q + 1'b1;
      nxt_grp  = grp_q;
    end
  end

  assign in_rom   = (step_q >= nass_pkg::S_ROM) && (step_q <= nass_pkg::S_ROM_LAST)
                    && (slot_q == 2'd2);
  assign in_reg   = (step_q >= nass_pkg::S_REG) && (step_q < nass_pkg::S_REG_END)
                    && (slot_q == 2'd2);
  assign echo_exp = 8'(nass_pkg::reg_word(grp_q));
  assign echo_bad = (rx_i[15:8] != 8'hFF) || (rx_i[7:0] != echo_exp);

  // Sequencer step
  always_comb begin
    res      = '0;
    phase_d  = phase_q;
    step_d   = step_q;
    slot_d   = slot_q;
    grp_d    = grp_q;
    init_d   = init_q;
    id_bad_d = id_bad_q;
    id_idx_d = id_idx_q;
    start_d  = start_q;
    stamp_d  = stamp_q;
    case (phase_q)
      PH_IDLE: begin
        if (req_i == nass_pkg::REQ_START) begin
          start_d      = now_i;
          init_d       = 1'b0;
          id_bad_d     = 1'b0;
          id_idx_d     = '0;
          phase_d      = PH_INIT;
          step_d       = '0;
          slot_d       = '0;
          grp_d        = '0;
          res.tx_valid = 1'b1;
          res.tx_word  = nass_pkg::init_cmd('0, 2'd0, '0);
        end else if (req_i == nass_pkg::REQ_TICK && init_q) begin
          stamp_d      = now_i - start_q;
          phase_d      = PH_FRAME;
          step_d       = '0;
          res.tx_valid = 1'b1;
          res.tx_word  = 16'h0000;
        end else begin
          res.status = nass_pkg::ST_REFUSED;
        end
      end
      PH_INIT: begin
        if (req_i != nass_pkg::REQ_WORD) begin
          res.status = nass_pkg::ST_REFUSED;
        end else begin
          // record the first bad ID character
          if (in_rom && !id_bad_q && rx_i[7:0] != nass_pkg::id_char(grp_q[2:0])) begin
            id_bad_d = 1'b1;
            id_idx_d = grp_q[2:0];
          end
          if (step_q == nass_pkg::S_ROM_LAST && id_bad_d) begin
            phase_d          = PH_IDLE;
            step_d           = '0;
            res.status       = nass_pkg::ST_ID_BAD;
            res.failed_index = 5'(id_idx_d);
          end else if (in_reg && echo_bad) begin
            phase_d          = PH_IDLE;
            step_d           = '0;
            res.status       = nass_pkg::ST_ECHO_BAD;
            res.failed_index = grp_q;
          end else if (step_q >= nass_pkg::S_LAST) begin
            phase_d    = PH_IDLE;
            step_d     = '0;
            init_d     = 1'b1;
            res.status = nass_pkg::ST_INIT_DONE;
          end else begin
            step_d       = nxt_step;
            slot_d       = nxt_slot;
            grp_d        = nxt_grp;
            res.tx_valid = 1'b1;
            res.tx_word  = nass_pkg::init_cmd(nxt_step, nxt_slot, nxt_grp);
          end
        end
      end
      PH_FRAME: begin
        if (req_i != nass_pkg::REQ_WORD) begin
          res.status = nass_pkg::ST_REFUSED;
        end else begin
          // replies two and on carry the conversions
          if (step_q >= 7'd2 && step_q < FRAME_END) begin
            res.sample_valid = 1'b1;
            res.channel      = 4'(step_q - 7'd2);
            res.sample_value = rx_i;
            res.timestamp    = stamp_q;
            res.frame_last   = (step_q == CH_LAST);
          end
          if (step_q >= FRAME_END) begin
            phase_d    = PH_IDLE;
            step_d     = '0;
            res.status = nass_pkg::ST_FRAME_END;
          end else begin
            step_d       = nxt_step;
            res.tx_valid = 1'b1;
            res.tx_word  = (nxt_step < CH_NUM) ? {1'b0, nxt_step, 8'h00} : nass_pkg::CMD_PAD;
          end
        end
      end
      default: begin
        phase_d    = PH_IDLE;
        res.status = nass_pkg::ST_REFUSED;
      end
    endcase
  end

  assign res_o = res;

  // Hold sequencer state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      step_q   <= '0;
      slot_q   <= '0;
      grp_q    <= '0;
      init_q   <= 1'b0;
      id_bad_q <= 1'b0;
      id_idx_q <= '0;
      start_q  <= '0;
      stamp_q  <= '0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      step_q   <= step_d;
      slot_q   <= slot_d;
      grp_q    <= grp_d;
      init_q   <= init_d;
      id_bad_q <= id_bad_d;
      id_idx_q <= id_idx_d;
      start_q  <= start_d;
      stamp_q  <= stamp_d;
    end
  end

endmodule

@@ hw/rtl/neural_adc_spi_sequencer.sv @@
// Path: an item moves from the input register through the sequencer step into
//   the result register; the step is a counter and a compare.
// Throughput: one item per cycle while the master side takes results.
// Reset: rst_ni low clears all control state; the sequencer comes up idle and
//   not initialized, with no result pending.
module neural_adc_spi_sequencer #(
  parameter int unsigned CHANNELS = nass_pkg::CHANNELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,  // rx_word[15:0], time_ms[47:16]
  input  logic [1:0]  s_axis_tuser_i,  // req_type[1:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,  // tx_word[15:0], channel[19:16],
                                       // sample_value[35:20], timestamp[67:36],
                                       // failed_index[72:68], zero[79:73]
  output logic [4:0]  m_axis_tuser_o,  // tx_valid[0], sample_valid[1], status[4:2]
  output logic        m_axis_tlast_o   // frame_last
);

  logic            in_vld_q;
  logic [1:0]      in_req_q;
  logic [15:0]     in_rx_q;
  logic [31:0]     in_time_q;
  logic            out_vld_q;
  nass_pkg::res_t  out_res_q;
  nass_pkg::res_t  res;
  logic            out_free, advance;

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign advance         = in_vld_q && out_free;
  assign s_axis_tready_o = !in_vld_q || out_free;

  nass_core #(
    .CHANNELS (CHANNELS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (advance),
    .req_i     (in_req_q),
    .rx_i      (in_rx_q),
    .now_i     (in_time_q),
    .res_o     (res)
  );

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_req_q  <= s_axis_tuser_i;
      in_rx_q   <= s_axis_tdata_i[15:0];
      in_time_q <= s_axis_tdata_i[47:16];
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res;
    end
  end

  // Pack the result item
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_res_q.failed_index, out_res_q.timestamp,
                            out_res_q.sample_value, out_res_q.channel, out_res_q.tx_word};
  assign m_axis_tuser_o  = {out_res_q.status, out_res_q.sample_valid, out_res_q.tx_valid};
  assign m_axis_tlast_o  = out_res_q.frame_last;

endmodule

@@ hw/rtl/nass_checker.sv @@
module nass_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [4:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Last channel of a frame is always a sample
  a_last_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o[1])
    else $error("frame_last without sample");

  // Any final status ends the command stream
  a_status_no_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[4:2] != nass_pkg::ST_BUSY |->
      !m_axis_tuser_o[0] && m_axis_tdata_o[15:0] == 16'h0000)
    else $error("command issued with a final status");

  // Failure index only with a check failure
  a_fail_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[72:68] != 5'd0 |->
      m_axis_tuser_o[4:2] == nass_pkg::ST_ID_BAD ||
      m_axis_tuser_o[4:2] == nass_pkg::ST_ECHO_BAD)
    else $error("failed_index without check failure");

  // No sample fields without a sample
  a_sample_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[1] |-> m_axis_tdata_o[67:16] == 52'd0)
    else $error("sample fields set without sample_valid");

endmodule

bind neural_adc_spi_sequencer nass_checker u_nass_checker (.*);

@@ sim/adc_seq_checker.sv @@
module adc_seq_checker
  import nass_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,     // rx_word[15:0], time_ms[47:16]
  input  logic [1:0]  s_tuser_i,     // req_type[1:0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [79:0] m_tdata_i,     // tx_word[15:0], channel[19:16], sample_value[35:20],
                                     // timestamp[67:36], failed_index[72:68], zero[79:73]
  input  logic [4:0]  m_tuser_i,     // tx_valid[0], sample_valid[1], status[4:2]
  input  logic        m_tlast_i,     // frame_last
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned samples_o,
  output int unsigned frames_o,
  output int unsigned startups_o,
  output int unsigned faults_o,
  output int unsigned refusals_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {SEQ_IDLE, SEQ_STARTUP, SEQ_FRAME} seq_phase_e;

  localparam int NCH         = CHANNELS_DEF;
  localparam int STARTUP_END = 95;

  // ID text read back from the ROM, first character at index 0
  localparam logic [4:0][7:0] ID_TEXT = {8'h4E, 8'h41, 8'h54, 8'h4E, 8'h49};

  // Register writes of the start-up sequence, first write at index 0
  localparam logic [17:0][15:0] REG_SETUP = {
    16'h91FF, 16'h90FF, 16'h8FFF, 16'h8EFF, 16'h8D3C, 16'h8C10,
    16'h8B15, 16'h8A08, 16'h8911, 16'h882C, 16'h8700, 16'h8600,
    16'h8500, 16'h84B0, 16'h8302, 16'h8228, 16'h8120, 16'h80DE
  };

  seq_phase_e  phase_q;
  logic [6:0]  step_q;
  logic        ready_q;
  logic [31:0] t_start_q;
  logic [31:0] t_tick_q;
  logic        id_fail_q;
  logic [2:0]  id_fail_at_q;
  res_t        due_q[$];
  int unsigned results_seen;

  // Command issued at start-up step s
  function automatic logic [15:0] startup_word(input int s);
    if (s < 12) return CMD_DUMMY;
    if (s < 15) return (s == 12) ? CMD_CLEAR : CMD_DUMMY;
    if (s < 30) begin
      if ((s - 15) % 3 == 0) return CMD_DUMMY | {2'b00, ROM_BASE + 6'((s - 15) / 3), 8'h00};
      return CMD_DUMMY;
    end
    if (s < 84) return ((s - 30) % 3 == 0) ? REG_SETUP[(s - 30) / 3] : CMD_DUMMY;
    if (s == 84) return CMD_CAL;
    if (s < 94) return CMD_PAD;
    return CMD_DUMMY;
  endfunction

  // Convert command for frame step s, padding after the last channel
  function automatic logic [15:0] frame_word(input int s);
    return (s < NCH) ? 16'(s << 8) : CMD_PAD;
  endfunction

  // Advance the sequencer by one request and return the result it gives
  function automatic res_t advance_sequencer(input logic [1:0] req, input logic [15:0] rx,
                                             input logic [31:0] now);
    res_t r;
    int   s;
    int   k;
    r        = '0;
    r.status = ST_BUSY;
    s        = int'(step_q);
    if (req == REQ_START && phase_q == SEQ_IDLE) begin
      t_start_q    = now;
      ready_q      = 1'b0;
      id_fail_q    = 1'b0;
      id_fail_at_q = '0;
      phase_q      = SEQ_STARTUP;
      step_q       = '0;
      r.tx_valid   = 1'b1;
      r.tx_word    = startup_word(0);
      return r;
    end
    if (req == REQ_TICK && phase_q == SEQ_IDLE && ready_q) begin
      t_tick_q   = now;
      phase_q    = SEQ_FRAME;
      step_q     = '0;
      r.tx_valid = 1'b1;
      r.tx_word  = frame_word(0);
      return r;
    end
    if (req != REQ_WORD || phase_q == SEQ_IDLE) begin
      r.status = ST_REFUSED;
      return r;
    end

    if (phase_q == SEQ_STARTUP) begin
      // ROM reply: remember the first bad character, judge after the last one
      if (s >= 15 && s < 30 && (s - 15) % 3 == 2) begin
        k = (s - 15) / 3;
        if (rx[7:0] != ID_TEXT[k] && !id_fail_q) begin
          id_fail_q    = 1'b1;
          id_fail_at_q = 3'(k);
        end
        if (s == 29 && id_fail_q) begin
          phase_q        = SEQ_IDLE;
          step_q         = '0;
          r.status       = ST_ID_BAD;
          r.failed_index = 5'(id_fail_at_q);
          return r;
        end
      end
      // Write echo: stop at the first bad one
      if (s >= 30 && s < 84 && (s - 30) % 3 == 2) begin
        k = (s - 30) / 3;
        if (rx != {8'hFF, REG_SETUP[k][7:0]}) begin
          phase_q        = SEQ_IDLE;
          step_q         = '0;
          r.status       = ST_ECHO_BAD;
          r.failed_index = 5'(k);
          return r;
        end
      end
      if (s >= STARTUP_END) begin
        phase_q  = SEQ_IDLE;
        step_q   = '0;
        ready_q  = 1'b1;
        r.status = ST_INIT_DONE;
        return r;
      end
      step_q     = 7'(s + 1);
      r.tx_valid = 1'b1;
      r.tx_word  = startup_word(s + 1);
      return r;
    end

    // Frame: replies lag two exchanges behind the convert commands
    if (s >= 2 && s < NCH + 2) begin
      r.sample_valid = 1'b1;
      r.channel      = 4'(s - 2);
      r.sample_value = rx;
      r.timestamp    = t_tick_q - t_start_q;
      r.frame_last   = (s == NCH + 1);
    end
    if (s >= NCH + 2) begin
      phase_q  = SEQ_IDLE;
      step_q   = '0;
      r.status = ST_FRAME_END;
      return r;
    end
    step_q     = 7'(s + 1);
    r.tx_valid = 1'b1;
    r.tx_word  = frame_word(s + 1);
    return r;
  endfunction

  // Count a mismatch, show only the first few
  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $display("mismatch on %s at result %0d: expected %0h, got %0h",
               what, results_seen, want, got);
    end
  endfunction

  // Predict on each accepted item, compare each accepted result in order
  always @(posedge clk_i or negedge rst_ni) begin : score
    res_t want;
    res_t got;
    if (!rst_ni) begin
      phase_q      = SEQ_IDLE;
      step_q       = '0;
      ready_q      = 1'b0;
      t_start_q    = '0;
      t_tick_q     = '0;
      id_fail_q    = 1'b0;
      id_fail_at_q = '0;
      due_q.delete();
      results_seen = 0;
      mismatches_o = 0;
      pending_o    = 0;
      samples_o    = 0;
      frames_o     = 0;
      startups_o   = 0;
      faults_o     = 0;
      refusals_o   = 0;
    end else begin
      // Take the result first so a same-edge item cannot hide an extra one
      if (m_tvalid_i && m_tready_i) begin
        got.tx_valid     = m_tuser_i[0];
        got.sample_valid = m_tuser_i[1];
        got.status       = m_tuser_i[4:2];
        got.tx_word      = m_tdata_i[15:0];
        got.channel      = m_tdata_i[19:16];
        got.sample_value = m_tdata_i[35:20];
        got.timestamp    = m_tdata_i[67:36];
        got.failed_index = m_tdata_i[72:68];
        got.frame_last   = m_tlast_i;
        if (due_q.size() == 0) begin
          flag_mismatch("result with nothing pending", 32'd0, m_tdata_i[31:0]);
        end else begin
          want = due_q.pop_front();
          if (want.tx_valid !== got.tx_valid)
            flag_mismatch("tx_valid", want.tx_valid, got.tx_valid);
          if (want.tx_word !== got.tx_word)
            flag_mismatch("tx_word", want.tx_word, got.tx_word);
          if (want.sample_valid !== got.sample_valid)
            flag_mismatch("sample_valid", want.sample_valid, got.sample_valid);
          if (want.channel !== got.channel)
            flag_mismatch("channel", want.channel, got.channel);
          if (want.sample_value !== got.sample_value)
            flag_mismatch("sample_value", want.sample_value, got.sample_value);
          if (want.timestamp !== got.timestamp)
            flag_mismatch("timestamp", want.timestamp, got.timestamp);
          if (want.status !== got.status)
            flag_mismatch("status", want.status, got.status);
          if (want.failed_index !== got.failed_index)
            flag_mismatch("failed_index", want.failed_index, got.failed_index);
          if (want.frame_last !== got.frame_last)
            flag_mismatch("frame_last", want.frame_last, got.frame_last);
        end
        results_seen++;
      end
      if (s_tvalid_i && s_tready_i) begin
        want = advance_sequencer(s_tuser_i, s_tdata_i[15:0], s_tdata_i[47:16]);
        due_q.push_back(want);
        if (want.sample_valid) samples_o++;
        if (want.status == ST_FRAME_END) frames_o++;
        if (want.status == ST_INIT_DONE) startups_o++;
        if (want.status == ST_ID_BAD || want.status == ST_ECHO_BAD) faults_o++;
        if (want.status == ST_REFUSED) refusals_o++;
      end
      pending_o = due_q.size();
    end
  end

endmodule

@@ sim/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nass_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;
  localparam int RUN_ITEMS   = 750;
  localparam int CALM_AFTER  = 650;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  typedef enum int {INIT_CLEAN, INIT_ID_FAULT, INIT_ECHO_FAULT} init_fault_e;

  logic        clk_i    = 1'b0;
  logic        rst_n    = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;   // rx_word[15:0], time_ms[47:16]
  logic [1:0]  s_tuser  = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;         // tx_word, channel, sample_value, timestamp, failed_index
  logic [4:0]  m_tuser;         // tx_valid[0], sample_valid[1], status[4:2]
  logic        m_tlast;         // frame_last

  int unsigned mismatches, pending, samples, frames, startups, faults, refusals;
  int unsigned items_sent  = 0;
  int unsigned idle_cycles = 0;
  bit          quiet       = 1'b0;
  bit          hold_req    = 1'b0;
  bit          hold_served = 1'b0;
  bit          init_ok     = 1'b0;

  always #10 clk_i = ~clk_i;

  neural_adc_spi_sequencer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  adc_seq_checker chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .samples_o    (samples),
    .frames_o     (frames),
    .startups_o   (startups),
    .faults_o     (faults),
    .refusals_o   (refusals)
  );

  // Offer one item, with an occasional gap before it, and hold until taken
  task automatic push_item(input logic [1:0] req, input logic [15:0] rx,
                           input logic [31:0] now);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, rx};
    s_tuser  <= req;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    items_sent++;
    if (items_sent == HOLD_AT) hold_req = 1'b1;
    if (items_sent >= CALM_AFTER) quiet = 1'b1;
  endtask

  // Now and then slip in a start, tick or unknown request while busy
  task automatic poke_busy();
    logic [1:0] req;
    if ($urandom_range(0, 99) < 4) begin
      case ($urandom_range(0, 2))
        0:       req = REQ_START;
        1:       req = REQ_TICK;
        default: req = REQ_BAD;
      endcase
      push_item(req, 16'($urandom), $urandom);
    end
  endtask

  // Start-up run; a fault spoils ROM replies from a chosen one on, or one write echo
  task automatic run_init(input logic [31:0] t0, input init_fault_e fault, input int at);
    int          s;
    int          k;
    logic [15:0] rx;
    bit          echo_slot;
    push_item(REQ_START, 16'($urandom), t0);
    init_ok = 1'b0;
    for (s = 0; s < 96; s++) begin
      rx        = 16'($urandom);
      echo_slot = 1'b0;
      k         = 0;
      if (s >= 15 && s < 30 && (s - 15) % 3 == 2) begin
        k        = (s - 15) / 3;
        rx[7:0]  = id_char(3'(k));
        // Spoil the chosen character and maybe some later ones
        if (fault == INIT_ID_FAULT && (k == at || (k > at && $urandom_range(0, 1) == 1)))
          rx[7:0] ^= 8'($urandom_range(1, 255));
      end
      if (s >= 30 && s < 84 && (s - 30) % 3 == 2) begin
        k         = (s - 30) / 3;
        echo_slot = 1'b1;
        rx        = {8'hFF, 8'(reg_word(5'(k)))};
        if (fault == INIT_ECHO_FAULT && k == at) begin
          case ($urandom_range(0, 2))
            0:       rx[15:8] = 8'($urandom_range(0, 254));
            1:       rx[7:0] ^= 8'($urandom_range(1, 255));
            default: rx ^= 16'($urandom_range(1, 65535));
          endcase
        end
      end
      poke_busy();
      push_item(REQ_WORD, rx, $urandom);
      if (fault == INIT_ID_FAULT && s == 29) return;
      if (fault == INIT_ECHO_FAULT && echo_slot && k == at) return;
    end
    init_ok = (fault == INIT_CLEAN);
  endtask

  // One tick and the replies of a full frame
  task automatic run_frame(input logic [31:0] t_tick);
    int s;
    push_item(REQ_TICK, 16'($urandom), t_tick);
    for (s = 0; s < CHANNELS_DEF + 3; s++) begin
      poke_busy();
      push_item(REQ_WORD, 16'($urandom), $urandom);
    end
  endtask

  // Stall the result side in bursts, once for a long stretch
  initial begin : sink
    wait (rst_n === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : source
    int pick;
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Requests refused while idle and not yet initialized
    push_item(REQ_WORD, 16'h0000, 32'h0000_0000);
    push_item(REQ_WORD, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(REQ_TICK, 16'hFFFF, 32'hFFFF_FFFF);
    push_item(REQ_BAD,  16'hFFFF, 32'hFFFF_FFFF);
    push_item(REQ_BAD,  16'h0000, 32'h0000_0000);
    push_item(REQ_TICK, 16'h0000, 32'h0000_0000);

    // Start at the top of the clock range so the first stamps wrap
    run_init(32'hFFFF_FFFF, INIT_CLEAN, 0);
    run_frame(32'h0000_0000);
    run_frame(32'hFFFF_FFFF);

    // Mostly well-formed runs, some faults and stray requests
    while (items_sent < RUN_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (init_ok && pick < 70) begin
        run_frame($urandom);
      end else if (pick < (init_ok ? 78 : 55)) begin
        run_init($urandom, INIT_CLEAN, 0);
      end else if (pick < (init_ok ? 85 : 70)) begin
        run_init($urandom, INIT_ID_FAULT, $urandom_range(0, 4));
      end else if (pick < (init_ok ? 92 : 85)) begin
        run_init($urandom, INIT_ECHO_FAULT, $urandom_range(0, 17));
      end else begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 2))
            0:       push_item(REQ_WORD, 16'($urandom), $urandom);
            1:       push_item(REQ_BAD, 16'($urandom), $urandom);
            default: push_item(init_ok ? REQ_BAD : REQ_TICK, 16'($urandom), $urandom);
          endcase
        end
      end
    end
    s_tvalid <= 1'b0;

    // Drain outstanding results, then allow for the pipeline
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Sent %0d items: %0d start-ups completed, %0d ID or echo faults, %0d refused.",
             items_sent, startups, faults, refusals);
    $display("Checked %0d frames carrying %0d channel samples, %0d mismatches.",
             frames, samples, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/nass_pkg.sv
hw/rtl/nass_core.sv
hw/rtl/neural_adc_spi_sequencer.sv
hw/rtl/nass_checker.sv
sim/adc_seq_checker.sv
sim/tb.sv
